@@ rtl/tdcr_pkg.sv @@
package tdcr_pkg;

  localparam int unsigned MAX_DIAL_DEF = 8;
  localparam logic [15:0] INTERVAL_RESET = 16'd250;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [5:0] ENDPOINT_BASE = 6'd32;

  typedef enum logic [0:0] {
    OP_DIAL = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] dial;
    logic [7:0] dial_value;
  } tdcr_in_t;

  typedef struct packed {
    logic [5:0] endpoint_id;
    logic [7:0] report_value;
    logic       last_report;
  } tdcr_out_t;

  // One dial's record in the store
  typedef struct packed {
    logic [7:0] cur_val;
    logic       cur_seen;
    logic [7:0] rep_val;
    logic       rep_seen;
  } tdcr_entry_t;

  localparam int unsigned ENTRY_W = $bits(tdcr_entry_t);

endpackage

@@ rtl/tdcr_ram.sv @@
module tdcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/tdcr_ctrl.sv @@
module tdcr_ctrl
  import tdcr_pkg::*;
#(
  parameter int unsigned MAX_DIAL = MAX_DIAL_DEF,
  localparam int unsigned DIAL_COUNT = MAX_DIAL + 1,
  localparam int unsigned IW = $clog2(DIAL_COUNT)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tdcr_in_t          in_data_i,
  input  logic [15:0]       min_interval_i,
  input  logic              slot_free_i,
  output logic              emit_o,
  output tdcr_out_t         result_o,
  output logic              ram_wr_en_o,
  output logic [IW-1:0]     ram_wr_addr_o,
  output logic [ENTRY_W-1:0] ram_wr_data_o,
  output logic              ram_rd_en_o,
  output logic [IW-1:0]     ram_rd_addr_o,
  input  logic [ENTRY_W-1:0] ram_rd_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_FIRST,
    ST_SCAN
  } state_e;

  state_e                state_q, state_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [7:0]            val_q, val_d;
  logic [DIAL_COUNT-1:0] vdiff_q, vdiff_d;
  logic [DIAL_COUNT-1:0] sdiff_q, sdiff_d;
  logic [DIAL_COUNT-1:0] valid_q, valid_d;
  logic                  rd_valid_q, rd_valid_d;
  logic [15:0]           elapsed_q, elapsed_d;

  tdcr_entry_t           rd_entry;
  tdcr_entry_t           wr_entry;
  logic                  stall;
  logic                  later_change;

  // Entries never written read as the reset record
  assign rd_entry = rd_valid_q ? tdcr_entry_t'(ram_rd_data_i) : '0;
  assign in_ready_o = (state_q == ST_IDLE);
  assign stall = vdiff_q[idx_q] && !slot_free_i;

  always_comb begin
    later_change = 1'b0;
    for (int j = 0; j < DIAL_COUNT; j++) begin
      if (vdiff_q[j] && (IW'(j) > idx_q)) begin
        later_change = 1'b1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    val_d      = val_q;
    vdiff_d    = vdiff_q;
    sdiff_d    = sdiff_q;
    elapsed_d  = elapsed_q;
    wr_entry   = rd_entry;
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = idx_q;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = idx_q;
    emit_o        = 1'b0;
    result_o.endpoint_id  = ENDPOINT_BASE + 6'(idx_q);
    result_o.report_value = rd_entry.cur_val;
    result_o.last_report  = !later_change;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.operation == OP_TICK) begin
            if (elapsed_q != ELAPSED_MAX) begin
              elapsed_d = elapsed_q + 16'd1;
            end
          end else if (in_data_i.dial <= 8'(MAX_DIAL)) begin
            ram_rd_en_o   = 1'b1;
            ram_rd_addr_o = in_data_i.dial[IW-1:0];
            idx_d         = in_data_i.dial[IW-1:0];
            val_d         = in_data_i.dial_value;
            state_d       = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        wr_entry.cur_val  = val_q;
        wr_entry.cur_seen = 1'b1;
        ram_wr_en_o       = 1'b1;
        vdiff_d[idx_q]    = (val_q != rd_entry.rep_val);
        sdiff_d[idx_q]    = !rd_entry.rep_seen;
        if (((|vdiff_d) || (|sdiff_d)) && (elapsed_q >= min_interval_i)) begin
          state_d = ST_FIRST;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FIRST: begin
        // Separate from the update write so dial 0 reads back fresh
        ram_rd_en_o   = 1'b1;
        ram_rd_addr_o = '0;
        idx_d         = '0;
        state_d       = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stall) begin
          wr_entry.rep_val  = rd_entry.cur_val;
          wr_entry.rep_seen = rd_entry.cur_seen;
          ram_wr_en_o       = 1'b1;
          emit_o            = vdiff_q[idx_q];
          vdiff_d[idx_q]    = 1'b0;
          sdiff_d[idx_q]    = 1'b0;
          if (idx_q == IW'(MAX_DIAL)) begin
            elapsed_d = '0;
            state_d   = ST_IDLE;
          end else begin
            ram_rd_en_o   = 1'b1;
            ram_rd_addr_o = idx_q + IW'(1);
            idx_d         = idx_q + IW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ram_wr_data_o = wr_entry;

  always_comb begin
    valid_d = valid_q;
    if (ram_wr_en_o) begin
      valid_d[ram_wr_addr_o] = 1'b1;
    end
    rd_valid_d = rd_valid_q;
    if (ram_rd_en_o) begin
      rd_valid_d = valid_q[ram_rd_addr_o];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      vdiff_q    <= '0;
      sdiff_q    <= '0;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      elapsed_q  <= ELAPSED_MAX;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      vdiff_q    <= vdiff_d;
      sdiff_q    <= sdiff_d;
      valid_q    <= valid_d;
      rd_valid_q <= rd_valid_d;
      elapsed_q  <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  a_scan_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= IW'(MAX_DIAL)))
    else $error("scan index beyond last dial");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> (slot_free_i && state_q == ST_SCAN))
    else $error("result issued without a free output slot");

  a_round_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && state_d == ST_IDLE)
      |=> (elapsed_q == '0 && vdiff_q == '0 && sdiff_q == '0))
    else $error("round finished with stale change marks or counter");

endmodule

@@ rtl/throttled_dial_change_reporter.sv @@
// A tick only updates the elapsed counter; a dial event without a round reads its store
// entry, then writes it back. A round then reads dial 0 and scans every store entry in
// turn, one store entry per cycle while the output is not stalled; results leave in dial
// order.
// Flow: one item at a time; a new item is taken only once the last one is finished.
// Reset: asynchronous active low; store reads as all zero, elapsed counter saturated, interval 250.
module throttled_dial_change_reporter
  import tdcr_pkg::*;
#(
  parameter int unsigned MAX_DIAL = MAX_DIAL_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tdcr_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output tdcr_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned DIAL_COUNT = MAX_DIAL + 1;
  localparam int unsigned IW = $clog2(DIAL_COUNT);

  logic [15:0]        min_interval_q;
  logic               out_valid_q;
  tdcr_out_t          out_data_q;
  logic               slot_free;
  logic               emit;
  tdcr_out_t          result;
  logic               ram_wr_en;
  logic [IW-1:0]      ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [IW-1:0]      ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_interval_q <= INTERVAL_RESET;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        min_interval_q <= cfg_data_i;
      end
      // hold the beat until taken, refill in the same cycle
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  tdcr_ctrl #(
    .MAX_DIAL (MAX_DIAL)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .min_interval_i (min_interval_q),
    .slot_free_i    (slot_free),
    .emit_o         (emit),
    .result_o       (result),
    .ram_wr_en_o    (ram_wr_en),
    .ram_wr_addr_o  (ram_wr_addr),
    .ram_wr_data_o  (ram_wr_data),
    .ram_rd_en_o    (ram_rd_en),
    .ram_rd_addr_o  (ram_rd_addr),
    .ram_rd_data_i  (ram_rd_data)
  );

  tdcr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DIAL_COUNT)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

endmodule

@@ tb/sv/dial_report_checker.sv @@
`timescale 1ns / 1ps

module dial_report_checker
  import tdcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  tdcr_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  tdcr_out_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  localparam int unsigned DIALS = MAX_DIAL_DEF + 1;
  localparam int REPORT_LIMIT = 10;

  logic [7:0]  cur_val  [DIALS];
  logic        cur_seen [DIALS];
  logic [7:0]  rep_val  [DIALS];
  logic        rep_seen [DIALS];
  logic [15:0] elapsed_ms;
  logic [15:0] min_interval;
  tdcr_out_t   expected_reports [$];
  tdcr_out_t   oldest_report;

  task automatic predict_reports(input tdcr_in_t item);
    int        last_dial;
    bit        differ;
    tdcr_out_t rep;
    if (item.operation == OP_TICK) begin
      if (elapsed_ms != ELAPSED_MAX) elapsed_ms = elapsed_ms + 16'd1;
      return;
    end
    // drop events for dials beyond the top one
    if (item.dial > MAX_DIAL_DEF) return;
    cur_val[item.dial]  = item.dial_value;
    cur_seen[item.dial] = 1'b1;
    differ    = 1'b0;
    last_dial = -1;
    for (int d = 0; d < DIALS; d++) begin
      if (cur_seen[d] != rep_seen[d] || cur_val[d] != rep_val[d]) differ = 1'b1;
      if (cur_val[d] != rep_val[d]) last_dial = d;
    end
    if (!differ || elapsed_ms < min_interval) return;
    // a round: a newly seen dial at zero counts as a change but emits nothing
    for (int d = 0; d < DIALS; d++) begin
      if (cur_val[d] != rep_val[d]) begin
        rep.endpoint_id  = ENDPOINT_BASE + 6'(d);
        rep.report_value = cur_val[d];
        rep.last_report  = (d == last_dial);
        expected_reports.push_back(rep);
      end
      rep_val[d]  = cur_val[d];
      rep_seen[d] = cur_seen[d];
    end
    elapsed_ms = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < DIALS; d++) begin
        cur_val[d]  = '0;
        cur_seen[d] = 1'b0;
        rep_val[d]  = '0;
        rep_seen[d] = 1'b0;
      end
      elapsed_ms   = ELAPSED_MAX;
      min_interval = INTERVAL_RESET;
      expected_reports.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) min_interval = cfg_data_i;
      if (in_valid_i && in_ready_i) predict_reports(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          if (mismatch_count_o < REPORT_LIMIT)
            $display("%0t: unexpected report ep %0d val %02h last %0b", $realtime,
                     out_data_i.endpoint_id, out_data_i.report_value,
                     out_data_i.last_report);
          mismatch_count_o++;
        end else begin
          oldest_report = expected_reports.pop_front();
          if (out_data_i.endpoint_id !== oldest_report.endpoint_id ||
              out_data_i.report_value !== oldest_report.report_value ||
              out_data_i.last_report !== oldest_report.last_report) begin
            if (mismatch_count_o < REPORT_LIMIT)
              $display("%0t: report mismatch: expected ep %0d val %02h last %0b, got ep %0d val %02h last %0b",
                       $realtime, oldest_report.endpoint_id, oldest_report.report_value,
                       oldest_report.last_report, out_data_i.endpoint_id,
                       out_data_i.report_value, out_data_i.last_report);
            mismatch_count_o++;
          end
        end
      end
      pending_count_o = expected_reports.size();
    end
  end

endmodule

@@ tb/sv/tb_throttled_dial_change_reporter.sv @@
`timescale 1ns / 1ps

module tb_throttled_dial_change_reporter;
  import tdcr_pkg::*;

  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  tdcr_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  tdcr_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  int mismatch_count;
  int pending_count;
  int cycle_count   = 0;
  int hold_requests = 0;
  bit gaps_on       = 1'b1;
  int burst_left    = 0;

  always #1 clk_i = ~clk_i;

  throttled_dial_change_reporter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  dial_report_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  function automatic tdcr_in_t make_item(op_e op, logic [7:0] dial, logic [7:0] value);
    tdcr_in_t item;
    item.operation  = op;
    item.dial       = dial;
    item.dial_value = value;
    return item;
  endfunction

  function automatic tdcr_in_t random_item(int unsigned tick_pct);
    int unsigned r;
    logic [7:0]  value;
    r = $urandom_range(0, 99);
    if (r < tick_pct) return make_item(OP_TICK, 8'($urandom), 8'($urandom));
    if (r < tick_pct + 8)
      return make_item(OP_DIAL, 8'($urandom_range(9, 255)), 8'($urandom));
    // favour a few values so that repeats and returns to zero are common
    case ($urandom_range(0, 5))
      0:       value = 8'h00;
      1:       value = 8'hFF;
      2:       value = 8'h01;
      3:       value = 8'h80;
      default: value = 8'($urandom);
    endcase
    return make_item(OP_DIAL, 8'($urandom_range(0, MAX_DIAL_DEF)), value);
  endfunction

  // Called and returns at a falling edge; valid stays high into the next beat.
  task automatic send_item(input tdcr_in_t item);
    int unsigned gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    // let an event without reports finish in the store
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_interval(input logic [15:0] interval);
    drain_block();
    cfg_data  <= interval;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] interval, input int count,
                           input int unsigned tick_pct, input bit gaps, input bit with_hold);
    write_interval(interval);
    gaps_on = gaps;
    if (with_hold) hold_requests <= hold_requests + 1;
    repeat (count) send_item(random_item(tick_pct));
  endtask

  // Receiver: switches between randomly chosen stall patterns; long hold on request.
  initial begin
    int mode;
    int left;
    int hold_left;
    int holds_done;
    mode       = 0;
    left       = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 80);
        end
        left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((left / 4) % 2 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // counter starts saturated, so even the widest interval lets a round run
    write_interval(16'hFFFF);
    repeat (3) send_item(make_item(OP_TICK, 8'h00, 8'h00));
    send_item(make_item(OP_DIAL, 8'd3, 8'h00));
    send_item(make_item(OP_DIAL, 8'd5, 8'h80));
    send_item(make_item(OP_DIAL, 8'd200, 8'hFF));
    send_item(make_item(OP_DIAL, 8'd9, 8'h01));
    send_item(make_item(OP_DIAL, 8'd255, 8'h00));

    write_interval(16'd0);
    send_item(make_item(OP_DIAL, 8'd5, 8'h80));
    send_item(make_item(OP_DIAL, 8'd0, 8'hFF));
    send_item(make_item(OP_DIAL, 8'd8, 8'h01));
    send_item(make_item(OP_DIAL, 8'd8, 8'h01));
    send_item(make_item(OP_DIAL, 8'd0, 8'h00));
    send_item(make_item(OP_TICK, 8'hFF, 8'hFF));

    write_interval(16'd2);
    send_item(make_item(OP_DIAL, 8'd1, 8'h55));
    send_item(make_item(OP_TICK, 8'h00, 8'h00));
    send_item(make_item(OP_DIAL, 8'd2, 8'hAA));
    send_item(make_item(OP_TICK, 8'h00, 8'h00));
    send_item(make_item(OP_DIAL, 8'd1, 8'h55));

    // hold every dial back, then release them in one full round
    write_interval(16'hFFFF);
    for (int d = 0; d <= MAX_DIAL_DEF; d++)
      send_item(make_item(OP_DIAL, 8'(d), 8'(8'h10 + d)));
    write_interval(16'd0);
    send_item(make_item(OP_DIAL, 8'd4, 8'h14));

    run_phase(16'd0, 30, 15, 1'b1, 1'b0);
    run_phase(16'd0, 30, 10, 1'b0, 1'b1);
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 3))
        0:       run_phase(16'd0, 15, 20, ($urandom_range(0, 3) != 0), 1'b0);
        1:       run_phase(16'($urandom_range(1, 4)), 15, 45, ($urandom_range(0, 3) != 0),
                           1'b0);
        2:       run_phase(16'hFFFF, 15, 30, ($urandom_range(0, 3) != 0), 1'b0);
        default: run_phase(16'($urandom_range(5, 20)), 15, 60, ($urandom_range(0, 3) != 0),
                           1'b0);
      endcase
    end
    // the default interval needs long runs of ticks between rounds
    run_phase(INTERVAL_RESET, 140, 92, 1'b1, 1'b0);

    drain_block();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
